@@ rtl/nsm_pkg.sv @@
package nsm_pkg;

	// stream payload layout
	localparam int ENTRY_W     = 7;
	localparam int ELEM_W      = 16;
	localparam int FIELD_COUNT = 7;
	localparam int IN_TDATA_W  = 120;
	localparam int IDENT_W     = 8;
	localparam int DIST_W      = 35;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - IDENT_W - DIST_W;

	// configuration port
	localparam int LEN_W      = 3;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 35;

	localparam logic [CFG_IDX_W-1:0] REG_SIG_LEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 2'd2;

	localparam logic [LEN_W-1:0]   SIG_LEN_RST   = 3'd5;
	localparam logic [COUNT_W-1:0] ENT_COUNT_RST = 8'd32;
	localparam logic [DIST_W-1:0]  THRESH_RST    = 35'd6039798;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// item kinds carried on s_tuser
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic valid;
		logic last;
	} dist_ctl_t;

endpackage

@@ rtl/nsm_ram.sv @@
module nsm_ram #(
	parameter int WIDTH = 112,
	parameter int DEPTH = 128
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/nsm_dist.sv @@
module nsm_dist #(
	parameter int LANES      = 7,
	parameter int VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nsm_pkg::dist_ctl_t            in_ctl,
	input  logic [LANES*VALUE_BITS-1:0]   row_data,
	input  logic [LANES*VALUE_BITS-1:0]   query,
	input  logic [nsm_pkg::LEN_W-1:0]     sig_len,
	output nsm_pkg::dist_ctl_t            out_ctl,
	output logic [nsm_pkg::DIST_W-1:0]    dist_sq
);

	import nsm_pkg::*;

	localparam int SQ_W   = 2 * VALUE_BITS;
	localparam int PAIRS  = (LANES + 1) / 2;
	localparam int PAIR_W = SQ_W + 1;
	localparam int SUM_W  = PAIR_W + ((PAIRS > 1) ? $clog2(PAIRS) : 0) + 1;
	localparam int CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	logic [VALUE_BITS-1:0] diff [LANES];
	logic [SQ_W-1:0]       sq_pad [2*PAIRS];
	logic [PAIR_W-1:0]     pair_d [PAIRS];
	logic [CMP_W-1:0]      sum_d;

	logic [SQ_W-1:0]       sq_s2 [LANES];
	logic [PAIR_W-1:0]     pair_s3 [PAIRS];
	logic [DIST_W-1:0]     dist_s4;
	dist_ctl_t             ctl_s2, ctl_s3, ctl_s4;

	// absolute difference per lane, lanes past the length count as zero
	always_comb begin
		logic [VALUE_BITS-1:0] a, b;
		for (int k = 0; k < LANES; k++) begin
			a = query[k*VALUE_BITS +: VALUE_BITS];
			b = row_data[k*VALUE_BITS +: VALUE_BITS];
			diff[k] = (a >= b) ? (a - b) : (b - a);
			if (k >= int'(sig_len)) begin
				diff[k] = '0;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 2*PAIRS; k++) begin
			sq_pad[k] = (k < LANES) ? sq_s2[(k < LANES) ? k : 0] : '0;
		end
		for (int p = 0; p < PAIRS; p++) begin
			pair_d[p] = PAIR_W'(sq_pad[2*p]) + PAIR_W'(sq_pad[2*p+1]);
		end
	end

	always_comb begin
		sum_d = '0;
		for (int p = 0; p < PAIRS; p++) begin
			sum_d = sum_d + CMP_W'(pair_s3[p]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= in_ctl;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES; k++) begin
			sq_s2[k] <= SQ_W'(diff[k]) * SQ_W'(diff[k]);
		end
		for (int p = 0; p < PAIRS; p++) begin
			pair_s3[p] <= pair_d[p];
		end
		// saturate at the top of the distance range
		dist_s4 <= (sum_d > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_d);
	end

	assign out_ctl = ctl_s4;
	assign dist_sq = dist_s4;

endmodule

@@ rtl/nearest_signature_match.sv @@
// nearest signature match: nearest-row lookup over a bank of signature rows
// with a reject threshold on the squared distance.
// input channel s_*: one beat per item. s_tuser selects the kind: a load beat
//   writes the row given by entry_index with up to seven Q4.12 elements, a
//   query beat carries one signature to identify.
// output channel m_*: one beat per query, none per load. m_tuser is the match
//   flag, m_tdata carries the 1-based row (0 when rejected) and the best
//   squared distance in Q11.24.
// config port: cfg_we, cfg_index and cfg_data write signature length, entry
//   count and squared threshold; write only while no query is in flight.
// a load writes the row memory directly. a query streams the first entry_count rows out of
//   the row memory at one row per cycle through a four-stage distance pipe
//   (memory read, squares, pair sums, total); the input stays closed until the query's
//   result is handed to the output register, and an empty bank skips the scan.
// the result sits in an output register: while it waits on m_tready the next
//   items are already accepted, and a later query holds in its final state
//   until the register frees up.
// reset clears control and configuration to their defaults; the row memory
//   is not cleared and rows must be loaded before a query scans them.
module nearest_signature_match #(
	parameter int MAX_ENTRIES = 128,
	parameter int MAX_LENGTH  = 7,
	parameter int VALUE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nsm_pkg::IN_TDATA_W-1:0]      s_tdata,  // entry_index, element_0..element_6, pad
	input  logic                                s_tuser,  // mode
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nsm_pkg::OUT_TDATA_W-1:0]     m_tdata,  // identity, best_distance_sq, pad
	output logic                                m_tuser,  // matched
	// configuration writes
	input  logic                                cfg_we,
	input  logic [nsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import nsm_pkg::*;

	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ROW_W  = MAX_LENGTH * VALUE_BITS;
	localparam int PAD_N  = (MAX_LENGTH > FIELD_COUNT) ? MAX_LENGTH : FIELD_COUNT;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// configuration
	logic [LEN_W-1:0]   sig_len_q;
	logic [COUNT_W-1:0] ent_count_q;
	logic [DIST_W-1:0]  thresh_q;

	// control
	state_t             state_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [CNT_W-1:0]   rows_q;
	logic [ADDR_W-1:0]  cmp_row_q;
	logic               found_q;
	logic [DIST_W-1:0]  best_q;
	logic [ADDR_W-1:0]  best_row_q;
	logic               m_tvalid_q;
	dist_ctl_t          rd_ctl_s1;

	// payload
	logic [ROW_W-1:0]   query_q;
	logic               m_matched_q;
	logic [IDENT_W-1:0] m_ident_q;
	logic [DIST_W-1:0]  m_dist_q;

	logic                  in_accept;
	logic                  is_query;
	logic                  idx_ok;
	logic [CNT_W-1:0]      rows_nx;
	logic [ROW_W-1:0]      row_in;
	logic [VALUE_BITS-1:0] elem_pad [PAD_N];
	logic                  issue;
	logic                  issue_last;
	logic                  out_free;
	logic [ROW_W-1:0]      ram_rdata;
	dist_ctl_t             dist_ctl;
	logic [DIST_W-1:0]     dist_sq;

	assign in_accept = s_tvalid && s_tready;
	assign is_query  = (s_tuser == MODE_QUERY);
	assign s_tready  = (state_q == ST_IDLE);
	assign idx_ok    = (32'(s_tdata[ENTRY_W-1:0]) < MAX_ENTRIES);
	assign rows_nx   = (32'(ent_count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
	                                                     : CNT_W'(ent_count_q);
	assign out_free  = !m_tvalid_q || m_tready;

	// unpack elements, elements without a field read as zero
	always_comb begin
		for (int k = 0; k < PAD_N; k++) begin
			elem_pad[k] = '0;
		end
		for (int k = 0; k < FIELD_COUNT; k++) begin
			elem_pad[k] = VALUE_BITS'(s_tdata[ENTRY_W + k*ELEM_W +: ELEM_W]);
		end
		for (int k = 0; k < MAX_LENGTH; k++) begin
			row_in[k*VALUE_BITS +: VALUE_BITS] = elem_pad[k];
		end
	end

	// row fetch during the scan
	assign issue      = (state_q == ST_SCAN);
	assign issue_last = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == rows_q);

	nsm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_ENTRIES)
	) u_bank (
		.clk   (clk),
		.we    (in_accept && (s_tuser == MODE_LOAD) && idx_ok),
		.waddr (ADDR_W'(s_tdata[ENTRY_W-1:0])),
		.wdata (row_in),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	nsm_dist #(
		.LANES      (MAX_LENGTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (rd_ctl_s1),
		.row_data (ram_rdata),
		.query    (query_q),
		.sig_len  (sig_len_q),
		.out_ctl  (dist_ctl),
		.dist_sq  (dist_sq)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_len_q   <= SIG_LEN_RST;
			ent_count_q <= ENT_COUNT_RST;
			thresh_q    <= THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIG_LEN:   sig_len_q   <= cfg_data[LEN_W-1:0];
				REG_ENT_COUNT: ent_count_q <= cfg_data[COUNT_W-1:0];
				REG_THRESH:    thresh_q    <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, running minimum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_addr_q  <= '0;
			rows_q     <= '0;
			cmp_row_q  <= '0;
			found_q    <= 1'b0;
			best_q     <= DIST_MAX;
			best_row_q <= '0;
			m_tvalid_q <= 1'b0;
			rd_ctl_s1  <= '0;
		end else begin
			rd_ctl_s1.valid <= issue;
			rd_ctl_s1.last  <= issue && issue_last;

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// first strictly smaller distance wins, so ties keep the lower row
			if (dist_ctl.valid) begin
				if (!found_q || (dist_sq < best_q)) begin
					best_q     <= dist_sq;
					best_row_q <= cmp_row_q;
					found_q    <= 1'b1;
				end
				cmp_row_q <= cmp_row_q + ADDR_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && is_query) begin
						rows_q    <= rows_nx;
						rd_addr_q <= '0;
						cmp_row_q <= '0;
						found_q   <= 1'b0;
						best_q    <= DIST_MAX;
						state_q   <= (rows_nx == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (dist_ctl.valid && dist_ctl.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query signature and result payload
	always_ff @(posedge clk) begin
		if (in_accept && is_query) begin
			query_q <= row_in;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_matched_q <= found_q && (best_q <= thresh_q);
			m_ident_q   <= (found_q && (best_q <= thresh_q))
			               ? (IDENT_W'(best_row_q) + IDENT_W'(1)) : '0;
			m_dist_q    <= best_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_matched_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_dist_q, m_ident_q};

endmodule

@@ rtl/nsm_checker.sv @@
module nsm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [nsm_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	import nsm_pkg::*;

	// a stalled result beat holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a rejected query reports identity zero
	a_reject_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[IDENT_W-1:0] == '0)
		else $error("identity set on a rejected query");

	// a match names a row, never zero
	a_match_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[IDENT_W-1:0] != '0)
		else $error("match with identity zero");

	// a query keeps the input closed on the following cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_QUERY) |=> !s_tready)
		else $error("input open right after a query beat");

endmodule

bind nearest_signature_match nsm_checker u_nsm_checker (.*);
